// ===== rtl/tic_pkg.sv =====
// ----------------------------------------------------------------------------
// tic_pkg
// Types and constants shared by the total ink coverage check.
// ----------------------------------------------------------------------------
`default_nettype none

package tic_pkg;

    // Register map, indexed by paddr[3:2].
    typedef enum logic [1:0] {
        REG_LIMIT  = 2'd0,
        REG_STEP   = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } reg_idx_t;

    // Page verdict codes.
    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_OK       = 2'd1,
        VERDICT_NEAR     = 2'd2,
        VERDICT_EXCEEDED = 2'd3
    } verdict_t;

    localparam int LIMIT_W = 9;
    localparam int STEP_W  = 8;
    localparam int DIM_W   = 16;
    localparam int SUM_W   = 10;

    // Exact compare widths and scale factors.
    // Exceeded: sum*10000 > 25500*limit + 255.
    // Near:     sum*1000  > 2295*limit.
    localparam int OVER_W = 24;
    localparam int NEAR_W = 21;

    localparam logic [OVER_W-1:0] OVER_SUM_SCALE   = 24'd10000;
    localparam logic [OVER_W-1:0] OVER_LIMIT_SCALE = 24'd25500;
    localparam logic [OVER_W-1:0] OVER_LIMIT_BIAS  = 24'd255;
    localparam logic [NEAR_W-1:0] NEAR_SUM_SCALE   = 21'd1000;
    localparam logic [NEAR_W-1:0] NEAR_LIMIT_SCALE = 21'd2295;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 9'd300;
    localparam logic [STEP_W-1:0]  STEP_RESET   = 8'd10;
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 16'd1;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 16'd1;

endpackage

`default_nettype wire

// ===== rtl/cmyk_total_ink_coverage_check_core.sv =====
// ----------------------------------------------------------------------------
// cmyk_total_ink_coverage_check_core
// Samples CMYK pixels on a stride grid and reports the page ink verdict.
// ----------------------------------------------------------------------------
// Usage:
// Pixels of the page's images arrive in raster order on the slave stream.
// Each transaction carries the four ink bytes in s_tdata, s_tuser set when
// it holds a pixel, and s_tlast on the last transaction of the page. A
// transaction with s_tuser low and s_tlast high is a bare page-end marker.
// Only the page-end transaction produces a result: the verdict and the
// largest sampled ink sum, sent on the master stream.
// Image size, sampling stride and limit are set over the APB port; the
// user must write them only while the block is idle, which the block does
// not enforce. The position counters wrap to a new image after the last
// pixel of the last row, and a page end clears all page state.
// A result passes the input register, then the processing stage into
// the result register. One transaction is accepted per cycle unless a
// page-end one waits; position, maximum and stop flag update per pixel.
// When the receiver stalls, the result register holds its transaction and
// pixels keep flowing; only a page-end transaction waits in the input
// register until the result register is free.
// Reset (aresetn low, synchronous) empties both registers, clears the page
// state and loads the register defaults: limit 300, step 10, size 1 by 1.
// ----------------------------------------------------------------------------
`default_nettype none

module cmyk_total_ink_coverage_check_core
    import tic_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Pixel stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // cyan[7:0], magenta[15:8], yellow[23:16], black[31:24]
    input  wire logic        s_tuser,   // pixel_valid
    input  wire logic        s_tlast,   // page_end

    // Verdict stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // verdict[1:0], max_ink_sum[11:2], zero[15:12]
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LIMIT_W-1:0] limit_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    logic     cfg_write;
    reg_idx_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_LIMIT:  prdata = {23'd0, limit_reg};
            REG_STEP:   prdata = {24'd0, step_reg};
            REG_WIDTH:  prdata = {16'd0, width_reg};
            REG_HEIGHT: prdata = {16'd0, height_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg  <= LIMIT_RESET;
            step_reg   <= STEP_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_LIMIT:  limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_STEP:   step_reg   <= pwdata[STEP_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    // Last index of each counter; a zero setting behaves as one.
    logic [STEP_W-1:0] stride_last;
    logic [DIM_W-1:0]  col_last;
    logic [DIM_W-1:0]  row_last;

    assign stride_last = (step_reg == '0)   ? '0 : step_reg - 1'b1;
    assign col_last    = (width_reg == '0)  ? '0 : width_reg - 1'b1;
    assign row_last    = (height_reg == '0) ? '0 : height_reg - 1'b1;

    // Threshold terms use the limit only, kept static while busy by the user, not the block.
    logic [OVER_W-1:0] over_rhs;
    logic [NEAR_W-1:0] near_rhs;

    assign over_rhs = OVER_W'(limit_reg) * OVER_LIMIT_SCALE + OVER_LIMIT_BIAS;
    assign near_rhs = NEAR_W'(limit_reg) * NEAR_LIMIT_SCALE;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic        in_pixel_reg;
    logic        in_last_reg;
    logic [31:0] in_data_reg;

    logic out_free;
    logic fire;

    assign out_free = !m_tvalid || m_tready;
    // A page-end transaction may only leave when the result slot is free.
    assign fire     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pixel_reg <= s_tuser;
            in_last_reg  <= s_tlast;
            in_data_reg  <= s_tdata;
        end
    end

    // ------------------------------------------------------------------
    // Processing stage: sampling, page maximum, position advance
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]  col_reg,       col_next;
    logic [DIM_W-1:0]  row_reg,       row_next;
    logic [STEP_W-1:0] col_phase_reg, col_phase_next;
    logic [STEP_W-1:0] row_phase_reg, row_phase_next;
    logic [SUM_W-1:0]  max_reg,       max_next;
    logic              stopped_reg,   stopped_next;
    logic              seen_reg,      seen_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg,  m_tdata_next;

    logic [SUM_W-1:0]  ink_sum;
    logic              sample;
    logic              over_sum, over_cur, near_sum, near_cur;
    logic              over_new, near_new;
    verdict_t          verdict;

    assign ink_sum = SUM_W'(in_data_reg[7:0]) + SUM_W'(in_data_reg[15:8])
                   + SUM_W'(in_data_reg[23:16]) + SUM_W'(in_data_reg[31:24]);

    assign sample = in_pixel_reg && !stopped_reg
                 && (col_phase_reg == '0) && (row_phase_reg == '0);

    // The compares are monotone in the sum, so the test on the new maximum
    // splits into the test on the sample and the test on the old maximum.
    assign over_sum = (OVER_W'(ink_sum) * OVER_SUM_SCALE) > over_rhs;
    assign over_cur = (OVER_W'(max_reg) * OVER_SUM_SCALE) > over_rhs;
    assign near_sum = (NEAR_W'(ink_sum) * NEAR_SUM_SCALE) > near_rhs;
    assign near_cur = (NEAR_W'(max_reg) * NEAR_SUM_SCALE) > near_rhs;

    assign over_new = over_cur || (sample && over_sum);
    assign near_new = near_cur || (sample && near_sum);

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        max_next       = max_reg;
        stopped_next   = stopped_reg;
        seen_next      = seen_reg;
        verdict        = VERDICT_NONE;

        if (fire && in_pixel_reg) begin
            seen_next = 1'b1;
            if (sample) begin
                if (ink_sum > max_reg) begin
                    max_next = ink_sum;
                end
                if (over_new) begin
                    stopped_next = 1'b1;
                end
            end

            if (col_reg >= col_last) begin
                col_next       = '0;
                col_phase_next = '0;
                if (row_reg >= row_last) begin
                    // End of image: start the next one afresh.
                    row_next       = '0;
                    row_phase_next = '0;
                    stopped_next   = 1'b0;
                end else begin
                    row_next       = row_reg + 1'b1;
                    row_phase_next = (row_phase_reg >= stride_last) ? '0
                                                                    : row_phase_reg + 1'b1;
                end
            end else begin
                col_next       = col_reg + 1'b1;
                col_phase_next = (col_phase_reg >= stride_last) ? '0
                                                                : col_phase_reg + 1'b1;
            end
        end

        if (!seen_next) begin
            verdict = VERDICT_NONE;
        end else if (over_new) begin
            verdict = VERDICT_EXCEEDED;
        end else if (near_new) begin
            verdict = VERDICT_NEAR;
        end else begin
            verdict = VERDICT_OK;
        end

        // Result register: load on page end, otherwise drain when taken.
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (fire && in_last_reg) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'd0, (seen_next ? max_next : SUM_W'(0)), verdict};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Page end clears the whole page, including a partial image.
        if (fire && in_last_reg) begin
            col_next       = '0;
            row_next       = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            max_next       = '0;
            stopped_next   = 1'b0;
            seen_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            max_reg       <= '0;
            stopped_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            max_reg       <= max_next;
            stopped_reg   <= stopped_next;
            seen_reg      <= seen_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== dv/cmyk_total_ink_coverage_check_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cmyk_total_ink_coverage_check_core_tb
// Self-checking testbench for the total ink coverage check.
// ----------------------------------------------------------------------------
// Pixel and page-end transactions are driven on the slave stream while an
// internal model of the sampling grid, page maximum and stop flag predicts
// each page verdict. Verdicts on the master stream are compared field by
// field against the oldest prediction. A short directed table comes first,
// followed by randomised pages under a series of register settings, with
// random idling on both streams.
// ----------------------------------------------------------------------------

module cmyk_total_ink_coverage_check_core_tb;
    import tic_pkg::*;

    localparam int NUM_DIRECTED  = 17;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int ERA_ITEMS     = RANDOM_ITEMS / 3;
    localparam int PHASE_ITEMS   = 150;
    // Margin for the pipeline to empty before a register write.
    localparam int SETTLE_CYCLES = 4;
    localparam int LIMIT_CYCLES  = 400000;

    typedef struct {
        bit              pix;
        logic [7:0]      cyan;
        logic [7:0]      magenta;
        logic [7:0]      yellow;
        logic [7:0]      black;
        bit              last;
        bit              typed;
        verdict_t        verdict;
        logic [SUM_W-1:0] ink_sum;
    } stim_row_t;

    typedef struct {
        verdict_t         verdict;
        logic [SUM_W-1:0] ink_sum;
    } verdict_rec_t;

    // Clock and reset.
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    // APB configuration port.
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Pixel stream (slave side of the block).
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;     // cyan[7:0], magenta[15:8], yellow[23:16], black[31:24]
    logic        s_tuser  = 1'b0;   // pixel_valid
    logic        s_tlast  = 1'b0;   // page_end

    // Verdict stream (master side of the block).
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // verdict[1:0], max_ink_sum[11:2], zero[15:12]

    // Model copy of the registers.
    logic [LIMIT_W-1:0] cfg_limit;
    logic [STEP_W-1:0]  cfg_step;
    logic [DIM_W-1:0]   cfg_width;
    logic [DIM_W-1:0]   cfg_height;

    // Model copy of the sampling state.
    logic [DIM_W-1:0]   col_pos;
    logic [DIM_W-1:0]   row_pos;
    logic [STEP_W-1:0]  col_ph;
    logic [STEP_W-1:0]  row_ph;
    logic [SUM_W-1:0]   page_peak;
    bit                 img_halted;
    bit                 img_present;

    verdict_rec_t pending_verdicts[$];
    verdict_rec_t no_typed = '{VERDICT_NONE, '0};

    int unsigned mismatch_count  = 0;
    int unsigned stimulus_items  = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_idle_pct   = 34;
    int unsigned recv_idle_pct   = 88;

    // The directed table runs under the reset settings: limit 300 percent,
    // stride 10 and a 1 by 1 image, so every pixel is an image of its own
    // and is always sampled. At limit 300 the page is over the limit from a
    // sum of 766 and near it from a sum of 689.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, VERDICT_NONE,     10'd0},
        '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, VERDICT_OK,       10'd0},
        '{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, VERDICT_EXCEEDED, 10'd1020},
        '{1'b1, 8'd255, 8'd255, 8'd255, 8'd0, 1'b1, 1'b1, VERDICT_NEAR,   10'd765},
        '{1'b1, 8'd255, 8'd255, 8'd255, 8'd1, 1'b1, 1'b1, VERDICT_EXCEEDED, 10'd766},
        '{1'b1, 8'd255, 8'd255, 8'd179, 8'd0, 1'b1, 1'b1, VERDICT_NEAR,   10'd689},
        '{1'b1, 8'd255, 8'd255, 8'd178, 8'd0, 1'b1, 1'b1, VERDICT_OK,     10'd688},
        '{1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b1, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b1, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b1, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, VERDICT_OK,       10'd255},
        '{1'b0, 8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, VERDICT_NONE,     10'd0},
        '{1'b1, 8'h55, 8'hAA, 8'h0F, 8'hF0, 1'b0, 1'b0, VERDICT_NONE,     10'd0},
        '{1'b1, 8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b1, 1'b1, VERDICT_OK,       10'd510}
    };

    cmyk_total_ink_coverage_check_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Run-away guard: a healthy run finishes far below this count.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver stalls at random according to the current idling era.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each verdict transaction is checked against the oldest prediction.
    always @(posedge aclk) begin
        verdict_rec_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict transaction: m_tdata expected none, actual %h",
                       m_tdata);
                mismatch_count++;
            end else begin
                due = pending_verdicts.pop_front();
                if (m_tdata[1:0] !== due.verdict) begin
                    $error("verdict mismatch: expected %0d, actual %0d",
                           due.verdict, m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[11:2] !== due.ink_sum) begin
                    $error("max_ink_sum mismatch: expected %0d, actual %0d",
                           due.ink_sum, m_tdata[11:2]);
                    mismatch_count++;
                end
                if (m_tdata[15:12] !== 4'd0) begin
                    $error("padding mismatch: expected 0, actual %h", m_tdata[15:12]);
                    mismatch_count++;
                end
            end
        end
    end

    // Exact integer compares: over the limit when sum*100/255 exceeds the
    // limit by more than 0.01 percent, near it when above 90 percent.
    function automatic bit peak_exceeds(int unsigned sum);
        return sum * 10000 > 255 * (100 * int'(cfg_limit) + 1);
    endfunction

    function automatic bit peak_near(int unsigned sum);
        return sum * 1000 > 2295 * int'(cfg_limit);
    endfunction

    task automatic restart_image();
        col_pos    = '0;
        row_pos    = '0;
        col_ph     = '0;
        row_ph     = '0;
        img_halted = 1'b0;
    endtask

    task automatic predictor_reset();
        cfg_limit   = LIMIT_RESET;
        cfg_step    = STEP_RESET;
        cfg_width   = WIDTH_RESET;
        cfg_height  = HEIGHT_RESET;
        restart_image();
        page_peak   = '0;
        img_present = 1'b0;
    endtask

    // Works out the effect of one accepted transaction on the page state
    // and, on a page end, the verdict it must produce.
    task automatic ink_coverage_predict(input bit pix, input logic [31:0] inks,
                                        input bit last, output bit has_res,
                                        output verdict_rec_t rec);
        int unsigned stride;
        int unsigned wid;
        int unsigned hgt;
        int unsigned sum;
        // A zero stride or size behaves as one.
        stride  = (cfg_step == 0) ? 1 : cfg_step;
        wid     = (cfg_width == 0) ? 1 : cfg_width;
        hgt     = (cfg_height == 0) ? 1 : cfg_height;
        has_res = 1'b0;
        rec     = no_typed;
        if (pix) begin
            img_present = 1'b1;
            if (!img_halted && col_ph == 0 && row_ph == 0) begin
                sum = int'(inks[7:0]) + int'(inks[15:8]) + int'(inks[23:16])
                    + int'(inks[31:24]);
                if (sum > page_peak)
                    page_peak = SUM_W'(sum);
                if (peak_exceeds(page_peak))
                    img_halted = 1'b1;
            end
            // Counters and phases at or past their end wrap, which also
            // covers a size or stride lowered in the middle of an image.
            if (col_pos >= wid - 1) begin
                col_pos = '0;
                col_ph  = '0;
                if (row_pos >= hgt - 1) begin
                    restart_image();
                end else begin
                    row_pos = row_pos + 1'b1;
                    row_ph  = (row_ph >= stride - 1) ? '0 : row_ph + 1'b1;
                end
            end else begin
                col_pos = col_pos + 1'b1;
                col_ph  = (col_ph >= stride - 1) ? '0 : col_ph + 1'b1;
            end
        end
        if (last) begin
            has_res = 1'b1;
            if (!img_present)
                rec.verdict = VERDICT_NONE;
            else if (peak_exceeds(page_peak))
                rec.verdict = VERDICT_EXCEEDED;
            else if (peak_near(page_peak))
                rec.verdict = VERDICT_NEAR;
            else
                rec.verdict = VERDICT_OK;
            rec.ink_sum = img_present ? page_peak : '0;
            restart_image();
            page_peak   = '0;
            img_present = 1'b0;
        end
    endtask

    // One APB write; psel is left high so that writes can follow back to
    // back, and the caller lowers it after the last one.
    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_LIMIT:  cfg_limit  = value[LIMIT_W-1:0];
            REG_STEP:   cfg_step   = value[STEP_W-1:0];
            REG_WIDTH:  cfg_width  = value[DIM_W-1:0];
            REG_HEIGHT: cfg_height = value[DIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(int unsigned limit, int unsigned stride,
                                int unsigned wid, int unsigned hgt);
        apb_write(REG_LIMIT, limit);
        apb_write(REG_STEP, stride);
        apb_write(REG_WIDTH, wid);
        apb_write(REG_HEIGHT, hgt);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Holds the sender off until every predicted verdict has arrived and
    // the pipeline has emptied of pixels that produce no result.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Drives one transaction, waits for the handshake and records the
    // prediction. A typed row supplies its own expected verdict.
    task automatic send_item(bit pix, logic [31:0] inks, bit last, bit typed,
                             verdict_rec_t typed_rec);
        bit           has_res;
        verdict_rec_t rec;
        // Idling eras: sender light and receiver heavy, then swapped, then
        // a stretch at full rate on both sides.
        if (stimulus_items < ERA_ITEMS) begin
            send_idle_pct = 34;
            recv_idle_pct = 88;
        end else if (stimulus_items < 2 * ERA_ITEMS) begin
            send_idle_pct = 88;
            recv_idle_pct = 34;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= inks;
        s_tuser  <= pix;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        ink_coverage_predict(pix, inks, last, has_res, rec);
        if (has_res) begin
            if (typed)
                rec = typed_rec;
            pending_verdicts.insert(pending_verdicts.size(), rec);
        end
        if (pix || last)
            stimulus_items++;
    endtask

    // Ink bytes for one pixel. Mode 3 aims the sum just around the exceeded
    // or the near threshold of the current limit.
    function automatic logic [31:0] pick_ink(int unsigned mode);
        logic [31:0] inks;
        int          target;
        int          lo;
        int          hi;
        int          b;
        inks = '0;
        case (mode)
            0: inks = $urandom;
            1: for (b = 0; b < 4; b++) inks[8*b +: 8] = 8'($urandom_range(255, 200));
            2: for (b = 0; b < 4; b++) inks[8*b +: 8] = 8'($urandom_range(60, 0));
            default: begin
                if ($urandom_range(1))
                    target = int'(cfg_limit) * 255 / 100;
                else
                    target = int'(cfg_limit) * 2295 / 1000;
                target = target + int'($urandom_range(4)) - 2;
                if (target < 0)
                    target = 0;
                if (target > 1020)
                    target = 1020;
                // Split the target sum over the four bytes at random.
                for (b = 0; b < 4; b++) begin
                    lo = target - 255 * (3 - b);
                    if (lo < 0)
                        lo = 0;
                    hi = (target > 255) ? 255 : target;
                    inks[8*b +: 8] = 8'($urandom_range(hi, lo));
                    target = target - int'(inks[8*b +: 8]);
                end
            end
        endcase
        return inks;
    endfunction

    // Random register settings for most phases: small images and strides,
    // with the odd zero or widest value mixed in.
    task automatic write_random_config();
        int unsigned limit;
        int unsigned stride;
        int unsigned wid;
        int unsigned hgt;
        limit  = ($urandom_range(9) == 0) ? $urandom_range(511, 401) : $urandom_range(400);
        stride = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 255 : 0)
                                          : $urandom_range(4, 1);
        wid    = ($urandom_range(19) == 0) ? 65535 : $urandom_range(8);
        hgt    = ($urandom_range(19) == 0) ? 65535 : $urandom_range(6);
        write_config(limit, stride, wid, hgt);
    endtask

    // One page: mostly whole images, sometimes cut short by the page end,
    // sometimes empty, with ignored transactions sprinkled in as noise.
    task automatic run_random_page();
        longint unsigned area;
        int unsigned     n_pix;
        int unsigned     mode;
        int unsigned     i;
        bit              end_on_pixel;
        area = longint'((cfg_width == 0) ? 1 : cfg_width)
             * longint'((cfg_height == 0) ? 1 : cfg_height);
        mode = $urandom_range(3);
        if ($urandom_range(9) == 0)
            n_pix = 0;
        else if (area <= 48 && $urandom_range(2) != 0)
            n_pix = int'(area) * $urandom_range(3, 1);
        else
            n_pix = $urandom_range(40, 1);
        end_on_pixel = (n_pix != 0) && ($urandom_range(1) == 1);
        for (i = 0; i < n_pix; i++) begin
            if ($urandom_range(19) == 0)
                send_item(1'b0, $urandom, 1'b0, 1'b0, no_typed);
            // Now and then the stride and size change part way through an
            // image, once the block has gone idle.
            if (i != 0 && $urandom_range(199) == 0) begin
                drain_stream();
                write_random_config();
            end
            send_item(1'b1, pick_ink(mode), end_on_pixel && (i == n_pix - 1), 1'b0,
                      no_typed);
        end
        if (!end_on_pixel)
            send_item(1'b0, $urandom, 1'b1, 1'b0, no_typed);
    endtask

    initial begin
        int          r;
        int          phase;
        int unsigned phase_end;
        stim_row_t   row;

        predictor_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the reset settings.
        for (r = 0; r < NUM_DIRECTED; r++) begin
            row = directed_rows[r];
            send_item(row.pix, {row.black, row.yellow, row.magenta, row.cyan}, row.last,
                      row.typed, '{row.verdict, row.ink_sum});
        end

        // Zero stride and zero size behave as one: every pixel is sampled.
        drain_stream();
        write_config(300, 0, 0, 0);
        send_item(1'b1, pick_ink(0), 1'b0, 1'b0, no_typed);
        send_item(1'b1, pick_ink(1), 1'b1, 1'b0, no_typed);

        // A 3 by 3 image at stride 2, then the stride and width are lowered
        // in the middle of it so the phase and the column counter wrap.
        drain_stream();
        write_config(100, 2, 3, 3);
        for (r = 0; r < 4; r++)
            send_item(1'b1, pick_ink(0), 1'b0, 1'b0, no_typed);
        drain_stream();
        write_config(100, 1, 2, 3);
        for (r = 0; r < 3; r++)
            send_item(1'b1, pick_ink(0), 1'b0, 1'b0, no_typed);
        send_item(1'b0, $urandom, 1'b1, 1'b0, no_typed);

        // Random phases; the first few pin the register extremes.
        stimulus_items = 0;
        phase = 0;
        while (stimulus_items < RANDOM_ITEMS) begin
            drain_stream();
            case (phase)
                0: write_config(0, 1, $urandom_range(4, 1), $urandom_range(4, 1));
                1: write_config(400, 255, $urandom_range(8, 1), $urandom_range(6, 1));
                2: write_config(511, 0, 0, 0);
                3: write_config($urandom_range(400), 2, 65535, 2);
                4: write_config($urandom_range(400), 3, 3, 65535);
                default: write_random_config();
            endcase
            phase_end = stimulus_items + PHASE_ITEMS;
            while (stimulus_items < phase_end && stimulus_items < RANDOM_ITEMS)
                run_random_page();
            phase++;
        end

        drain_stream();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
